### hw/rtl/polar_cartesian_wind_converter_defines.svh
// Assertion macros for the wind converter
`ifndef POLAR_CARTESIAN_WIND_CONVERTER_DEFINES_SVH
`define POLAR_CARTESIAN_WIND_CONVERTER_DEFINES_SVH

// same-cycle implication
`define PCW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcw assertion failed");

// next-cycle implication
`define PCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcw assertion failed");

// fixed-delay implication
`define PCW_ASSERT_DELAY(label, clk, rst_n, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
    else $error("pcw assertion failed");

`endif

### hw/rtl/pcw_pkg.sv
// Shared types, constants and the arctangent table
`timescale 1ns / 1ps
`default_nettype none
package pcw_pkg;
  localparam int XW = 28;
  localparam int ZW = 27;
  localparam int TABLE_LEN = 24;
  localparam int DEG_FULL_Q6 = 23040;
  localparam logic signed [ZW-1:0] DEG90 = 27'sd5898240;
  localparam logic signed [ZW-1:0] DEG180 = 27'sd11796480;
  localparam logic signed [ZW:0] DEG360 = 28'sd23592960;
  localparam logic signed [16:0] INV_GAIN = 17'sd39797;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } pcw_vec_t;

  typedef struct packed {
    logic cmd;   // 1: vectoring (components to polar)
    logic miss;
    logic zero;
  } pcw_side_t;

  function automatic logic signed [ZW-1:0] pcw_atan(input int idx);
    logic signed [ZW-1:0] r;
    unique case (idx)
      0: r = 27'sd2949120;
      1: r = 27'sd1740967;
      2: r = 27'sd919879;
      3: r = 27'sd466945;
      4: r = 27'sd234379;
      5: r = 27'sd117304;
      6: r = 27'sd58666;
      7: r = 27'sd29335;
      8: r = 27'sd14668;
      9: r = 27'sd7334;
      10: r = 27'sd3667;
      11: r = 27'sd1833;
      12: r = 27'sd917;
      13: r = 27'sd458;
      14: r = 27'sd229;
      15: r = 27'sd115;
      16: r = 27'sd57;
      17: r = 27'sd29;
      18: r = 27'sd14;
      19: r = 27'sd7;
      20: r = 27'sd4;
      21: r = 27'sd2;
      22: r = 27'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

### hw/rtl/pcw_pre.sv
// Input stage: angle reduction and quadrant prerotation
`timescale 1ns / 1ps
`default_nettype none
module pcw_pre import pcw_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  wire logic               cmd_i,
  input  wire logic signed [15:0] first_value_i,
  input  wire logic signed [15:0] second_value_i,
  input  wire logic               missing_i,
  output logic                    valid_o,
  output pcw_vec_t                vec_o,
  output pcw_side_t               side_o
);
  logic signed [16:0] dir_r;
  logic signed [ZW-1:0] ang;
  logic signed [XW-1:0] spd, uu, vv;
  pcw_vec_t vec_d, vec_q;
  pcw_side_t side_d, side_q;
  logic valid_q;

  always_comb begin
    // direction modulo 360 degrees
    if (second_value_i >= 16'sd23040) begin
      dir_r = 17'(second_value_i) - 17'sd23040;
    end else if (second_value_i >= 16'sd0) begin
      dir_r = 17'(second_value_i);
    end else if (second_value_i >= -16'sd23040) begin
      dir_r = 17'(second_value_i) + 17'sd23040;
    end else begin
      dir_r = 17'(second_value_i) + 17'sd46080;
    end
    ang = ZW'(dir_r) <<< 10;
    if (ang > DEG180) ang = ang - ZW'(DEG360);
    spd = XW'(first_value_i) <<< 8;
    uu  = -(XW'(first_value_i) <<< 8);
    vv  = -(XW'(second_value_i) <<< 8);
    if (!cmd_i) begin
      vec_d = '{x: spd, y: '0, z: ang};
      if (ang > DEG90) begin
        vec_d = '{x: '0, y: spd, z: ang - DEG90};
      end else if (ang < -DEG90) begin
        vec_d = '{x: '0, y: -spd, z: ang + DEG90};
      end
    end else begin
      vec_d = '{x: vv, y: uu, z: '0};
      if (vv < 0) begin
        if (uu >= 0) vec_d = '{x: uu, y: -vv, z: DEG90};
        else         vec_d = '{x: -uu, y: vv, z: -DEG90};
      end
    end
    side_d.cmd  = cmd_i;
    side_d.miss = missing_i;
    side_d.zero = (first_value_i == 16'sd0) && (second_value_i == 16'sd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    vec_q  <= vec_d;
    side_q <= side_d;
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;
  assign side_o  = side_q;
endmodule
`default_nettype wire

### hw/rtl/pcw_stage.sv
// One registered CORDIC iteration, rotation or vectoring per item
`timescale 1ns / 1ps
`default_nettype none
module pcw_stage import pcw_pkg::*; #(
  parameter int IDX = 0
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      valid_i,
  input  wire pcw_vec_t  vec_i,
  input  wire pcw_side_t side_i,
  output logic           valid_o,
  output pcw_vec_t       vec_o,
  output pcw_side_t      side_o
);
  localparam logic signed [ZW-1:0] Atan = pcw_atan(IDX);
  logic pos;
  logic signed [XW-1:0] xs, ys;
  pcw_vec_t vec_d, vec_q;
  pcw_side_t side_q;
  logic valid_q;

  always_comb begin
    // rotate toward zero angle, or toward zero y when vectoring
    pos = side_i.cmd ? vec_i.y[XW-1] : !vec_i.z[ZW-1];
    xs  = vec_i.x >>> IDX;
    ys  = vec_i.y >>> IDX;
    if (pos) begin
      vec_d = '{x: vec_i.x - ys, y: vec_i.y + xs, z: vec_i.z - Atan};
    end else begin
      vec_d = '{x: vec_i.x + ys, y: vec_i.y - xs, z: vec_i.z + Atan};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    vec_q  <= vec_d;
    side_q <= side_i;
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;
  assign side_o  = side_q;
endmodule
`default_nettype wire

### hw/rtl/pcw_post.sv
// Gain compensation, rounding, saturation, direction wrap and floor, zeroing of missing results
`timescale 1ns / 1ps
`default_nettype none
module pcw_post import pcw_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  wire pcw_vec_t           vec_i,
  input  wire pcw_side_t          side_i,
  input  wire logic [6:0]         floor_i,
  output logic                    valid_o,
  output logic signed [15:0]      first_o,
  output logic signed [15:0]      second_o,
  output logic                    missing_o
);
  localparam int PW = XW + 17;
  logic signed [XW-1:0] opa, opb;
  logic signed [PW-1:0] pa_d, pb_d, pa_q, pb_q;
  logic signed [ZW-1:0] z_q;
  pcw_side_t side_q;
  logic valid_q, valid2_q;
  logic signed [PW-1:0] ra, rb;
  logic signed [20:0] sa, sb;
  logic signed [15:0] fa, fb, dir;
  logic signed [ZW:0] zz;
  logic [17:0] dq;
  logic signed [15:0] first_d, second_d;
  logic signed [15:0] first_q, second_q;
  logic missing_q;

  function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
    logic signed [15:0] r;
    if (v > 21'sd32767)       r = 16'sh7fff;
    else if (v < -21'sd32768) r = 16'sh8000;
    else                      r = v[15:0];
    return r;
  endfunction

  always_comb begin
    opa  = side_i.cmd ? vec_i.x : -vec_i.y;
    opb  = -vec_i.x;
    pa_d = PW'(opa) * PW'(INV_GAIN);
    pb_d = PW'(opb) * PW'(INV_GAIN);
  end

  always_ff @(posedge clk_i) begin
    pa_q   <= pa_d;
    pb_q   <= pb_d;
    z_q    <= vec_i.z;
    side_q <= side_i;
  end

  always_comb begin
    ra = pa_q + (PW'(1) <<< 23);
    rb = pb_q + (PW'(1) <<< 23);
    sa = ra[44:24];
    sb = rb[44:24];
    fa = sat16(sa);
    fb = sat16(sb);
    zz = z_q[ZW-1] ? (ZW+1)'(z_q) + DEG360 : (ZW+1)'(z_q);
    dq = 18'(unsigned'(zz + (ZW+1)'(512)) >> 10);
    if (dq >= 18'(DEG_FULL_Q6)) dq = dq - 18'(DEG_FULL_Q6);
    dir = 16'(dq);
    if (dq < {11'd0, floor_i}) dir = '0;
    if (side_q.miss || (side_q.cmd && side_q.zero)) begin
      first_d  = '0;
      second_d = '0;
    end else if (side_q.cmd) begin
      first_d  = fa;
      second_d = dir;
    end else begin
      first_d  = fa;
      second_d = fb;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      valid2_q <= 1'b0;
    end else begin
      valid_q  <= valid_i;
      valid2_q <= valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q   <= first_d;
    second_q  <= second_d;
    missing_q <= side_q.miss;
  end

  assign valid_o   = valid2_q;
  assign first_o   = first_q;
  assign second_o  = second_q;
  assign missing_o = missing_q;
endmodule
`default_nettype wire

### hw/rtl/polar_cartesian_wind_converter.sv
// Wind polar/Cartesian converter, pipelined CORDIC top level
//
//  channel  | ports                                    | handshake
//  command  | cmd_i first/second_value_i *_missing_i   | start_i & !busy_o
//  result   | first/second_result_o result_missing_o   | result_valid_o strobe
//  config   | cfg_wdata_i (direction floor)            | cfg_we_i
//
// One transaction per cycle; busy_o never rises.
// Registered path in order: input register, one register per
// CORDIC iteration, multiply register, output register.
// Reset clears the valid chain and the direction floor.
// No stalls: the receiver takes each result in its strobe cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "polar_cartesian_wind_converter_defines.svh"
module polar_cartesian_wind_converter import pcw_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic               cmd_i,
  input  wire logic signed [15:0] first_value_i,
  input  wire logic signed [15:0] second_value_i,
  input  wire logic               first_missing_i,
  input  wire logic               second_missing_i,
  input  wire logic               cfg_we_i,
  input  wire logic [6:0]         cfg_wdata_i,
  output logic                    result_valid_o,
  output logic signed [15:0]      first_result_o,
  output logic signed [15:0]      second_result_o,
  output logic                    result_missing_o
);
  localparam int Latency = CORDIC_STAGES + 3;

  logic [6:0] direction_floor_q;
  logic       vld [CORDIC_STAGES+1];
  pcw_vec_t   vec [CORDIC_STAGES+1];
  pcw_side_t  side [CORDIC_STAGES+1];

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_floor_q <= '0;
    end else if (cfg_we_i) begin
      direction_floor_q <= cfg_wdata_i;
    end
  end

  pcw_pre u_pre (
    .clk_i,
    .rst_ni,
    .valid_i        (start_i && !busy_o),
    .cmd_i,
    .first_value_i,
    .second_value_i,
    .missing_i      (first_missing_i || second_missing_i),
    .valid_o        (vld[0]),
    .vec_o          (vec[0]),
    .side_o         (side[0])
  );

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    pcw_stage #(.IDX(i)) u_stage (
      .clk_i,
      .rst_ni,
      .valid_i (vld[i]),
      .vec_i   (vec[i]),
      .side_i  (side[i]),
      .valid_o (vld[i+1]),
      .vec_o   (vec[i+1]),
      .side_o  (side[i+1])
    );
  end

  pcw_post u_post (
    .clk_i,
    .rst_ni,
    .valid_i   (vld[CORDIC_STAGES]),
    .vec_i     (vec[CORDIC_STAGES]),
    .side_i    (side[CORDIC_STAGES]),
    .floor_i   (direction_floor_q),
    .valid_o   (result_valid_o),
    .first_o   (first_result_o),
    .second_o  (second_result_o),
    .missing_o (result_missing_o)
  );

  `PCW_ASSERT_DELAY(a_latency, clk_i, rst_ni, start_i && !busy_o, Latency, result_valid_o)
  `PCW_ASSERT_NOW(a_miss_zero, clk_i, rst_ni, result_valid_o && result_missing_o, first_result_o == 16'sd0 && second_result_o == 16'sd0)
  `PCW_ASSERT_NEXT(a_cfg_write, clk_i, rst_ni, cfg_we_i, direction_floor_q == $past(cfg_wdata_i))
endmodule
`default_nettype wire
